>>> rtl/feed_packet_tag_parser_macros.svh
// Assertion macros for the feed packet tag parser RTL.
// No dependencies; included by fptp_seq, the module that carries assertions.
`ifndef FEED_PACKET_TAG_PARSER_MACROS_SVH
`define FEED_PACKET_TAG_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FPTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FPTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/fptp_pkg.sv
// Package for the feed packet tag parser: header layout constants, codes,
// and the structs passed between the parser and the result sequencer.
// No dependencies.
`timescale 1ns / 1ps

package fptp_pkg;

  // Header layout
  localparam int unsigned HDR_LEN      = 26;
  localparam int unsigned HDR_AW       = 5;
  localparam logic [HDR_AW-1:0] HDR_LAST = 5'(HDR_LEN - 1);
  localparam int unsigned ISSUE_FIRST  = 6;
  localparam int unsigned ISSUE_LEN    = 12;
  localparam int unsigned ISSUE_CW     = 4;
  localparam logic [7:0]  ASCII_SPACE  = 8'h20;

  localparam int unsigned OFS_GROUP    = 0;
  localparam int unsigned OFS_REBOOTS  = 1;
  localparam int unsigned OFS_SEQ      = 2;
  localparam int unsigned OFS_UPDATE   = 18;
  localparam int unsigned OFS_PKT_NUM  = 22;
  localparam int unsigned OFS_PKT_TOT  = 23;
  localparam int unsigned OFS_UTILITY  = 24;
  localparam int unsigned OFS_MSG_CNT  = 25;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_DROP = 2'd3
  } phase_t;

  // Result kind codes
  typedef enum logic [2:0] {
    KIND_HDR   = 3'd0,
    KIND_ISSUE = 3'd1,
    KIND_TAG   = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ABORT = 3'd4
  } kind_t;

  // Packet marker that closes a burst
  typedef enum logic [1:0] {
    TRAIL_NONE  = 2'd0,
    TRAIL_DONE  = 2'd1,
    TRAIL_ABORT = 2'd2
  } trail_t;

  // Results caused by one input byte, in emission order
  typedef struct packed {
    logic                hdr;
    logic [ISSUE_CW-1:0] iss_cnt;
    logic                tag;
    logic [7:0]          data;
    logic                start;
    trail_t              trail;
  } desc_t;

  // Result currently offered by the sequencer
  typedef struct packed {
    logic                valid;
    kind_t               kind;
    logic                final_res;
    logic [ISSUE_CW-1:0] iss_idx;
    logic [7:0]          data;
    logic                start;
  } sel_t;

endpackage

>>> rtl/fptp_in_if.sv
// Input channel of the feed packet tag parser: one payload byte per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface fptp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       datagram_end;

  modport source (output valid, output payload_byte, output datagram_end, input ready);
  modport sink   (input valid, input payload_byte, input datagram_end, output ready);
endinterface

>>> rtl/fptp_out_if.sv
// Result channel of the feed packet tag parser: one decoded result per request.
// Depends on nothing.
`timescale 1ns / 1ps

interface fptp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic        final_res;
  logic [31:0] seq_no;
  logic [31:0] upd_no;
  logic [7:0]  group_number;
  logic [7:0]  reboots;
  logic [7:0]  pkt_no;
  logic [7:0]  total_packets;
  logic [7:0]  util_flg;
  logic [7:0]  msg_cnt;
  logic [7:0]  data_byte;
  logic        tag_start;

  modport source (
    output valid, input ready, output kind, output final_res,
    output seq_no, output upd_no, output group_number,
    output reboots, output pkt_no, output total_packets,
    output util_flg, output msg_cnt, output data_byte, output tag_start
  );
  modport sink (
    input valid, output ready, input kind, input final_res,
    input seq_no, input upd_no, input group_number,
    input reboots, input pkt_no, input total_packets,
    input util_flg, input msg_cnt, input data_byte, input tag_start
  );
endinterface

>>> rtl/feed_packet_tag_parser.sv
// Top level of the feed packet tag parser: byte parser, header store and
// result sequencer. Depends on fptp_pkg, fptp_in_if, fptp_out_if, fptp_seq.
`timescale 1ns / 1ps
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+-----------------------------------------------
//  in_ch   | in  | valid/ready | payload_byte, datagram_end
//  out_ch  | out | valid/ready | kind, final_res, header fields, data_byte, ...
//
//  Takes one payload byte per cycle. A byte that completes a header raises
//  a burst of up to 14 results; the sequencer drains it one per cycle and
//  input waits until the last result of the burst is being taken.
//  Any other byte gives at most two results (tag byte, then packet marker).
//  rst_n is synchronous, active low; it clears the parser and the sequencer.
//  A stalled out_ch holds its result; input is taken again on the final pop.

module feed_packet_tag_parser
  import fptp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  fptp_in_if.sink    in_ch,
  fptp_out_if.source out_ch
);

  phase_t            phase_r,    phase_nxt;
  logic [HDR_AW-1:0] hpos_r,     hpos_nxt;
  logic [7:0]        tags_left_r, tags_left_nxt;
  logic [7:0]        bytes_left_r, bytes_left_nxt;
  logic              first_r,    first_nxt;
  logic [7:0]        hdr_store_r [HDR_LEN];

  logic              accept;
  logic              pop;
  logic              open_pkt;
  logic [7:0]        bl_dec;
  logic [7:0]        tl_dec;
  logic [ISSUE_CW-1:0] iss_cnt;
  logic [HDR_AW-1:0] iss_addr;
  desc_t             desc;
  logic              load;
  sel_t              sel;

  // Take a new byte when nothing is owed or the last owed result leaves now
  assign pop          = sel.valid && out_ch.ready;
  assign in_ch.ready  = !sel.valid || (out_ch.ready && sel.final_res);
  assign accept       = in_ch.valid && in_ch.ready;

  // Trimmed issue code length: highest non-space byte wins
  always_comb begin
    iss_cnt = '0;
    for (int i = 0; i < ISSUE_LEN; i++) begin
      if (hdr_store_r[ISSUE_FIRST + i] != ASCII_SPACE) begin
        iss_cnt = ISSUE_CW'(i + 1);
      end
    end
  end

  assign bl_dec = bytes_left_r - 8'd1;
  assign tl_dec = tags_left_r - 8'd1;

  // Parse one byte: next state and the results it causes
  always_comb begin
    phase_nxt      = phase_r;
    hpos_nxt       = hpos_r;
    tags_left_nxt  = tags_left_r;
    bytes_left_nxt = bytes_left_r;
    first_nxt      = first_r;
    open_pkt       = 1'b0;
    desc           = '0;
    desc.trail     = TRAIL_NONE;
    desc.data      = in_ch.payload_byte;
    desc.start     = first_r;
    case (phase_r)
      PH_HDR: begin
        if (hpos_r == HDR_LAST) begin
          hpos_nxt      = '0;
          desc.hdr      = 1'b1;
          desc.iss_cnt  = iss_cnt;
          tags_left_nxt = in_ch.payload_byte;
          if (in_ch.payload_byte == 8'd0) begin
            desc.trail = TRAIL_DONE;
          end else begin
            phase_nxt = PH_LEN;
            open_pkt  = 1'b1;
          end
        end else begin
          hpos_nxt = hpos_r + HDR_AW'(1);
        end
      end
      PH_LEN: begin
        if (in_ch.payload_byte == 8'd0) begin
          desc.trail = TRAIL_ABORT;
          phase_nxt  = PH_DROP;
        end else begin
          bytes_left_nxt = in_ch.payload_byte;
          first_nxt      = 1'b1;
          phase_nxt      = PH_BODY;
          open_pkt       = 1'b1;
        end
      end
      PH_BODY: begin
        desc.tag       = 1'b1;
        first_nxt      = 1'b0;
        bytes_left_nxt = bl_dec;
        if (bl_dec == 8'd0) begin
          tags_left_nxt = tl_dec;
          if (tl_dec == 8'd0) begin
            desc.trail = TRAIL_DONE;
            phase_nxt  = PH_HDR;
            hpos_nxt   = '0;
          end else begin
            phase_nxt = PH_LEN;
            open_pkt  = 1'b1;
          end
        end else begin
          open_pkt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    // End of datagram: abandon an open packet and start over
    if (in_ch.datagram_end) begin
      if (open_pkt) begin
        desc.trail = TRAIL_ABORT;
      end
      phase_nxt      = PH_HDR;
      hpos_nxt       = '0;
      tags_left_nxt  = '0;
      bytes_left_nxt = '0;
      first_nxt      = 1'b0;
    end
  end

  assign load = accept && (desc.hdr || desc.tag || (desc.trail != TRAIL_NONE));

  // Advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_HDR;
      hpos_r       <= '0;
      tags_left_r  <= '0;
      bytes_left_r <= '0;
      first_r      <= 1'b0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      hpos_r       <= hpos_nxt;
      tags_left_r  <= tags_left_nxt;
      bytes_left_r <= bytes_left_nxt;
      first_r      <= first_nxt;
    end
  end

  // Capture header bytes as they arrive
  always_ff @(posedge clk) begin
    if (accept && (phase_r == PH_HDR)) begin
      hdr_store_r[hpos_r] <= in_ch.payload_byte;
    end
  end

  fptp_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (load),
    .desc  (desc),
    .pop   (pop),
    .sel   (sel)
  );

  assign iss_addr = HDR_AW'(ISSUE_FIRST) + HDR_AW'(sel.iss_idx);

  // Drive the result fields; fields outside the result's kind read zero
  always_comb begin
    out_ch.valid         = sel.valid;
    out_ch.kind          = sel.kind;
    out_ch.final_res     = sel.final_res;
    out_ch.seq_no        = '0;
    out_ch.upd_no        = '0;
    out_ch.group_number  = '0;
    out_ch.reboots       = '0;
    out_ch.pkt_no        = '0;
    out_ch.total_packets = '0;
    out_ch.util_flg      = '0;
    out_ch.msg_cnt       = '0;
    out_ch.data_byte     = '0;
    out_ch.tag_start     = 1'b0;
    case (sel.kind)
      KIND_HDR: begin
        out_ch.seq_no        = {hdr_store_r[OFS_SEQ], hdr_store_r[OFS_SEQ + 1],
                                hdr_store_r[OFS_SEQ + 2], hdr_store_r[OFS_SEQ + 3]};
        out_ch.upd_no        = {hdr_store_r[OFS_UPDATE], hdr_store_r[OFS_UPDATE + 1],
                                hdr_store_r[OFS_UPDATE + 2], hdr_store_r[OFS_UPDATE + 3]};
        out_ch.group_number  = hdr_store_r[OFS_GROUP];
        out_ch.reboots       = hdr_store_r[OFS_REBOOTS];
        out_ch.pkt_no        = hdr_store_r[OFS_PKT_NUM];
        out_ch.total_packets = hdr_store_r[OFS_PKT_TOT];
        out_ch.util_flg      = hdr_store_r[OFS_UTILITY];
        out_ch.msg_cnt       = hdr_store_r[OFS_MSG_CNT];
      end
      KIND_ISSUE: begin
        out_ch.data_byte = hdr_store_r[iss_addr];
      end
      KIND_TAG: begin
        out_ch.data_byte = sel.data;
        out_ch.tag_start = sel.start;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/fptp_seq.sv
// Result sequencer: holds the results caused by one input byte and offers
// them in order, one per cycle while they are popped. Depends on fptp_pkg and the macros header.
`timescale 1ns / 1ps
`include "feed_packet_tag_parser_macros.svh"

module fptp_seq
  import fptp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  desc_t desc,
  input  logic  pop,
  output sel_t  sel
);

  logic                hdr_r,      hdr_nxt;
  logic [ISSUE_CW-1:0] iss_left_r, iss_left_nxt;
  logic [ISSUE_CW-1:0] iss_idx_r,  iss_idx_nxt;
  logic                tag_r,      tag_nxt;
  trail_t              trail_r,    trail_nxt;
  logic [7:0]          data_r,     data_nxt;
  logic                start_r,    start_nxt;

  logic has_iss;
  logic has_trail;

  // Pick the first pending result and flag it when nothing follows
  always_comb begin
    has_iss   = (iss_left_r != '0);
    has_trail = (trail_r != TRAIL_NONE);
    sel           = '0;
    sel.valid     = hdr_r | has_iss | tag_r | has_trail;
    sel.iss_idx   = iss_idx_r;
    sel.data      = data_r;
    sel.start     = start_r;
    if (hdr_r) begin
      sel.kind      = KIND_HDR;
      sel.final_res = !has_iss && !tag_r && !has_trail;
    end else if (has_iss) begin
      sel.kind      = KIND_ISSUE;
      sel.final_res = (iss_left_r == ISSUE_CW'(1)) && !tag_r && !has_trail;
    end else if (tag_r) begin
      sel.kind      = KIND_TAG;
      sel.final_res = !has_trail;
    end else begin
      sel.kind      = (trail_r == TRAIL_ABORT) ? KIND_ABORT : KIND_DONE;
      sel.final_res = 1'b1;
    end
  end

  // Retire the offered result on pop; take a new request on load
  always_comb begin
    hdr_nxt      = hdr_r;
    iss_left_nxt = iss_left_r;
    iss_idx_nxt  = iss_idx_r;
    tag_nxt      = tag_r;
    trail_nxt    = trail_r;
    data_nxt     = data_r;
    start_nxt    = start_r;
    if (pop) begin
      if (hdr_r) begin
        hdr_nxt = 1'b0;
      end else if (has_iss) begin
        iss_left_nxt = iss_left_r - ISSUE_CW'(1);
        iss_idx_nxt  = iss_idx_r + ISSUE_CW'(1);
      end else if (tag_r) begin
        tag_nxt = 1'b0;
      end else begin
        trail_nxt = TRAIL_NONE;
      end
    end
    if (load) begin
      hdr_nxt      = desc.hdr;
      iss_left_nxt = desc.iss_cnt;
      iss_idx_nxt  = '0;
      tag_nxt      = desc.tag;
      trail_nxt    = desc.trail;
      data_nxt     = desc.data;
      start_nxt    = desc.start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_r      <= 1'b0;
      iss_left_r <= '0;
      iss_idx_r  <= '0;
      tag_r      <= 1'b0;
      trail_r    <= TRAIL_NONE;
    end else begin
      hdr_r      <= hdr_nxt;
      iss_left_r <= iss_left_nxt;
      iss_idx_r  <= iss_idx_nxt;
      tag_r      <= tag_nxt;
      trail_r    <= trail_nxt;
    end
    data_r  <= data_nxt;
    start_r <= start_nxt;
  end

  // A new request never lands on results that are still owed
  `FPTP_ASSERT_NOW(a_load_when_free, clk, rst_n, load, !sel.valid || (pop && sel.final_res), "sequencer loaded while results pending")
  // An offered result that is not taken stays offered
  `FPTP_ASSERT_NEXT(a_hold_unpopped, clk, rst_n, sel.valid && !pop && !load, sel.valid, "pending result lost without pop")
  // Issue code never runs past its twelve bytes
  `FPTP_ASSERT_NOW(a_iss_bound, clk, rst_n, 1'b1, (iss_left_r + iss_idx_r) <= ISSUE_CW'(ISSUE_LEN), "issue code index out of range")

endmodule

>>> sim/fptp_result_check.sv
// Result checker for the feed packet tag parser: predicts the results of
// every accepted payload byte and compares them with the result channel.
// Depends on fptp_pkg, fptp_in_if and fptp_out_if.
`timescale 1ns / 1ps

module fptp_result_check
  import fptp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  fptp_in_if   in_mon,
  fptp_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    kind_t       kind;
    logic        final_res;
    logic [31:0] seq_num;
    logic [31:0] upd_num;
    logic [7:0]  grp_num;
    logic [7:0]  reboots;
    logic [7:0]  pkt_num;
    logic [7:0]  pkt_total;
    logic [7:0]  utility;
    logic [7:0]  msg_count;
    logic [7:0]  data;
    logic        tag_first;
  } parse_result_t;

  // Parser state as the block should hold it
  phase_t         parse_phase;
  logic [4:0]     hdr_pos;
  logic [7:0]     hdr_bytes [HDR_LEN];
  logic [7:0]     tags_left;
  logic [7:0]     body_left;
  logic           tag_first;

  parse_result_t  burst [$];
  parse_result_t  parse_results [$];
  int             mismatches = 0;

  function automatic parse_result_t blank_result(kind_t k);
    parse_result_t r;
    r = '0;
    r.kind = k;
    return r;
  endfunction

  function automatic logic [31:0] be_word(int unsigned at);
    return {hdr_bytes[at], hdr_bytes[at+1], hdr_bytes[at+2], hdr_bytes[at+3]};
  endfunction

  // Work out the results of one payload byte and queue them
  function automatic void parse_byte(logic [7:0] b, logic last);
    parse_result_t r;
    int            last_c;
    logic          open_pkt;
    open_pkt = 1'b0;
    burst.delete();
    case (parse_phase)
      PH_HDR: begin
        hdr_bytes[hdr_pos] = b;
        if (hdr_pos != HDR_LAST) begin
          hdr_pos = hdr_pos + 5'd1;
        end else begin
          hdr_pos = '0;
          r = blank_result(KIND_HDR);
          r.seq_num   = be_word(OFS_SEQ);
          r.upd_num   = be_word(OFS_UPDATE);
          r.grp_num   = hdr_bytes[OFS_GROUP];
          r.reboots   = hdr_bytes[OFS_REBOOTS];
          r.pkt_num   = hdr_bytes[OFS_PKT_NUM];
          r.pkt_total = hdr_bytes[OFS_PKT_TOT];
          r.utility   = hdr_bytes[OFS_UTILITY];
          r.msg_count = hdr_bytes[OFS_MSG_CNT];
          burst = {burst, r};
          // trim trailing spaces off the issue code
          last_c = ISSUE_FIRST + ISSUE_LEN - 1;
          while (last_c >= ISSUE_FIRST && hdr_bytes[last_c] == ASCII_SPACE) last_c--;
          for (int i = ISSUE_FIRST; i <= last_c; i++) begin
            r = blank_result(KIND_ISSUE);
            r.data = hdr_bytes[i];
            burst = {burst, r};
          end
          tags_left = hdr_bytes[OFS_MSG_CNT];
          if (tags_left == 8'd0) begin
            burst = {burst, blank_result(KIND_DONE)};
          end else begin
            parse_phase = PH_LEN;
            open_pkt = 1'b1;
          end
        end
      end
      PH_LEN: begin
        if (b == 8'd0) begin
          burst = {burst, blank_result(KIND_ABORT)};
          parse_phase = PH_DROP;
        end else begin
          body_left = b;
          tag_first = 1'b1;
          parse_phase = PH_BODY;
          open_pkt = 1'b1;
        end
      end
      PH_BODY: begin
        r = blank_result(KIND_TAG);
        r.data = b;
        r.tag_first = tag_first;
        burst = {burst, r};
        tag_first = 1'b0;
        body_left = body_left - 8'd1;
        if (body_left != 8'd0) begin
          open_pkt = 1'b1;
        end else begin
          tags_left = tags_left - 8'd1;
          if (tags_left == 8'd0) begin
            burst = {burst, blank_result(KIND_DONE)};
            parse_phase = PH_HDR;
            hdr_pos = '0;
          end else begin
            parse_phase = PH_LEN;
            open_pkt = 1'b1;
          end
        end
      end
      default: ;
    endcase
    // datagram end: abandon an open packet and start over
    if (last) begin
      if (open_pkt) burst = {burst, blank_result(KIND_ABORT)};
      parse_phase = PH_HDR;
      hdr_pos = '0;
      tags_left = '0;
      body_left = '0;
      tag_first = 1'b0;
    end
    if (burst.size() > 0) burst[burst.size()-1].final_res = 1'b1;
    parse_results = {parse_results, burst};
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    parse_result_t want;
    if (!rst_n) begin
      parse_phase = PH_HDR;
      hdr_pos     = '0;
      tags_left   = '0;
      body_left   = '0;
      tag_first   = 1'b0;
      parse_results.delete();
    end else begin
      // predict from the byte taken at this edge first
      if (in_mon.valid && in_mon.ready)
        parse_byte(in_mon.payload_byte, in_mon.datagram_end);
      // compare the result taken at this edge with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        if (parse_results.size() == 0) begin
          $display("%0t: result kind %0d arrived, expected none, got one", $time,
                   out_mon.kind);
          mismatches++;
        end else begin
          want = parse_results.pop_front();
          check_field("kind", 32'(want.kind), 32'(out_mon.kind));
          check_field("final_res", 32'(want.final_res), 32'(out_mon.final_res));
          check_field("seq_no", want.seq_num, out_mon.seq_no);
          check_field("upd_no", want.upd_num, out_mon.upd_no);
          check_field("group_number", 32'(want.grp_num), 32'(out_mon.group_number));
          check_field("reboots", 32'(want.reboots), 32'(out_mon.reboots));
          check_field("pkt_no", 32'(want.pkt_num), 32'(out_mon.pkt_no));
          check_field("total_packets", 32'(want.pkt_total), 32'(out_mon.total_packets));
          check_field("util_flg", 32'(want.utility), 32'(out_mon.util_flg));
          check_field("msg_cnt", 32'(want.msg_count), 32'(out_mon.msg_cnt));
          check_field("data_byte", 32'(want.data), 32'(out_mon.data_byte));
          check_field("tag_start", 32'(want.tag_first), 32'(out_mon.tag_start));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= parse_results.size();
  end

endmodule

>>> sim/tb_top.sv
// Testbench top for the feed packet tag parser: clock, reset, datagram
// stimulus, result-side backpressure, watchdog and verdict.
// Depends on fptp_pkg, the channel interfaces, the parser and fptp_result_check.
`timescale 1ns / 1ps

module tb_top;
  import fptp_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int TOTAL_ITEMS = 160;

  // header fill styles
  localparam int HDR_RANDOM = 0;
  localparam int HDR_ZEROS  = 1;
  localparam int HDR_ONES   = 2;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   quiet_cycles = 0;
  int   items_sent = 0;
  bit   send_gaps = 1'b1;
  bit   recv_gaps = 1'b1;
  bit   hold_req = 1'b0;

  fptp_in_if  in_ch ();
  fptp_out_if out_ch ();

  feed_packet_tag_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  fptp_result_check u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Append a 26-byte header; the tag count is given, the issue code has
  // issue_len leading bytes and spaces after them
  function automatic void add_header(ref logic [7:0] dg[$], input int fill,
                                     input logic [7:0] mc, input int issue_len);
    logic [7:0] v;
    int         pos;
    for (int i = 0; i < HDR_LEN; i++) begin
      pos = i - ISSUE_FIRST;
      if (i == OFS_MSG_CNT) begin
        v = mc;
      end else if (pos >= 0 && pos < ISSUE_LEN) begin
        if (pos >= issue_len) v = ASCII_SPACE;
        else if (fill == HDR_ONES) v = 8'hFF;
        else if (fill == HDR_ZEROS) v = 8'h00;
        else begin
          v = ($urandom_range(0, 3) == 0) ? ASCII_SPACE : 8'($urandom);
          if (pos == issue_len - 1 && v == ASCII_SPACE) v = 8'h5A;
        end
      end else begin
        v = (fill == HDR_ONES) ? 8'hFF : (fill == HDR_ZEROS) ? 8'h00 : 8'($urandom);
      end
      dg = {dg, v};
    end
  endfunction

  // Append tags, each a length byte and that many random bytes
  function automatic void add_tags(ref logic [7:0] dg[$], input int n, input int max_len);
    int len;
    for (int t = 0; t < n; t++) begin
      len = $urandom_range(1, max_len);
      dg = {dg, 8'(len)};
      repeat (len) dg = {dg, 8'($urandom)};
    end
  endfunction

  // Append a complete random packet
  function automatic void add_packet(ref logic [7:0] dg[$]);
    int mc;
    mc = $urandom_range(0, 3);
    add_header(dg, HDR_RANDOM, 8'(mc), $urandom_range(0, ISSUE_LEN));
    add_tags(dg, mc, ($urandom_range(0, 7) == 0) ? 40 : 5);
  endfunction

  // Offer one payload byte and hold it until it is taken
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = send_gaps ? $urandom_range(0, 19) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.payload_byte <= b;
    in_ch.datagram_end <= last;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    items_sent++;
  endtask

  task automatic send_datagram(input logic [7:0] dg[$]);
    for (int k = 0; k < dg.size(); k++) send_byte(dg[k], k == dg.size() - 1);
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = recv_gaps ? $urandom_range(0, 19) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("feed_packet_tag_parser regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [7:0] dg [$];
    int         pick;
    int         mc;
    int         keep;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.payload_byte = 8'h00;
    in_ch.datagram_end = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero header with blank issue code and no tags, then an all-ones
    // header with a full issue code and two tags
    dg.delete();
    add_header(dg, HDR_ZEROS, 8'd0, 0);
    add_header(dg, HDR_ONES, 8'd2, ISSUE_LEN);
    dg = {dg, 8'd1, 8'h00, 8'd3, 8'hFF, 8'h80, 8'h7F};
    send_datagram(dg);

    // zero tag length abandons the packet; the rest is dropped
    dg.delete();
    add_header(dg, HDR_RANDOM, 8'd3, 4);
    add_tags(dg, 1, 3);
    dg = {dg, 8'd0};
    repeat (2) dg = {dg, 8'($urandom)};
    send_datagram(dg);

    // datagram ends inside a tag body
    dg.delete();
    add_header(dg, HDR_RANDOM, 8'd255, 7);
    dg = {dg, 8'd5, 8'($urandom), 8'($urandom)};
    send_datagram(dg);

    // hold the result side off across the longest burst: the datagram ends
    // on the byte that completes a header while later bytes keep coming
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    hold_req  = 1'b1;
    dg.delete();
    add_header(dg, HDR_RANDOM, 8'd1, ISSUE_LEN);
    send_datagram(dg);

    // incomplete header alone, then a one-byte datagram
    dg.delete();
    repeat (10) dg = {dg, 8'($urandom)};
    send_datagram(dg);
    send_byte(8'($urandom), 1'b1);

    // random datagrams, mostly well formed
    while (items_sent < TOTAL_ITEMS) begin
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      dg.delete();
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        repeat ($urandom_range(1, 2)) add_packet(dg);
      end else if (pick == 6) begin
        // cut short somewhere inside the last packet's tags
        if ($urandom_range(0, 1) == 1) add_packet(dg);
        keep = dg.size() + HDR_LEN;
        mc = $urandom_range(1, 3);
        add_header(dg, HDR_RANDOM, 8'(mc), $urandom_range(0, ISSUE_LEN));
        add_tags(dg, mc, 5);
        keep = $urandom_range(keep, dg.size() - 1);
        dg = dg[0:keep-1];
      end else if (pick == 7) begin
        mc = $urandom_range(1, 4);
        add_header(dg, HDR_RANDOM, 8'(mc), $urandom_range(0, ISSUE_LEN));
        add_tags(dg, $urandom_range(0, mc - 1), 5);
        dg = {dg, 8'd0};
        repeat ($urandom_range(0, 5)) dg = {dg, 8'($urandom)};
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 30)) dg = {dg, 8'($urandom)};
      end else begin
        add_packet(dg);
        repeat ($urandom_range(1, HDR_LEN - 1)) dg = {dg, 8'($urandom)};
      end
      send_datagram(dg);
    end

    // drain and give the verdict
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("feed_packet_tag_parser regression: pass");
    end else begin
      $display("feed_packet_tag_parser regression: fail");
    end
    $finish;
  end

endmodule
